FILE: sv/tfr_pkg.sv
`timescale 1ns / 1ps
// Package for the tiled framebuffer rasterizer.
// Command codes and plot-request types; no dependencies.
package tfr_pkg;
	typedef enum logic [2:0] {
		CMD_PIXEL  = 3'd0,
		CMD_LINE   = 3'd1,
		CMD_CIRCLE = 3'd2,
		CMD_THICK  = 3'd3,
		CMD_RECT   = 3'd4,
		CMD_CLEAR  = 3'd5,
		CMD_READ   = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	localparam int unsigned REG_TILES_WIDE = 0;
	localparam int unsigned REG_TILES_HIGH = 1;

	// One pixel request from the shape walker to the plotter.
	typedef struct packed {
		logic       valid;
		logic [7:0] x;
		logic [7:0] y;
	} plot_req_t;
endpackage

FILE: sv/tfr_plot.sv
`timescale 1ns / 1ps
// Pixel plotter: maps pixels to row bytes and ORs them into the frame memory.
// Depends on tfr_pkg. Owns the frame memory, its clear sweep and the read port.
module tfr_plot import tfr_pkg::*; #(
	parameter int MAX_TILES_WIDE = 8,
	parameter int MAX_TILES_HIGH = 4,
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [3:0]      tiles_wide,
	input  logic [2:0]      tiles_high,
	input  plot_req_t       req,
	input  logic            clear_start,
	output logic            clear_busy,
	input  logic            rd_en,
	input  logic [7:0]      rd_index,
	output logic [7:0]      rd_data,
	output logic            idle
);
	localparam int unsigned MW = MAX_TILES_WIDE;
	localparam int unsigned MH = MAX_TILES_HIGH;

	logic [7:0] mem [2**AW];

	logic [4:0]  tw, th;
	logic        hit;
	logic [15:0] idx_full;

	always_comb begin
		tw = (32'(tiles_wide) > MW) ? 5'(MW) : 5'(tiles_wide);
		th = (32'(tiles_high) > MH) ? 5'(MH) : 5'(tiles_high);
		idx_full = 16'({req.x[7:3], 3'b000}) + 16'(req.y[7:3]) * 16'({tw, 3'b000})
			+ 16'(req.y[2:0]);
		hit = req.valid && ({3'b000, req.x} < 11'({tw, 3'b000}))
			&& ({3'b000, req.y} < 11'({th, 3'b000})) && (32'(idx_full) < DEPTH);
	end

	// stage 1 holds the row read, ORs the bit in and writes it back
	logic          v_s1, v_s2;
	logic [AW-1:0] a_s1, a_s2;
	logic [7:0]    m_s1;
	logic [7:0]    q_s1, wd_s1, wd_s2;
	logic [AW:0]   clr_q;
	logic          rd_v_s1;
	logic          rd_ok_s1;
	logic [AW-1:0] rd_addr;

	assign rd_addr = AW'(rd_index);
	assign clear_busy = clr_q[AW] == 1'b0 ? 1'b1 : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			clr_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			v_s1    <= hit;
			v_s2    <= v_s1;
			rd_v_s1 <= rd_en;
			if (clear_start) clr_q <= '0;
			else if (!clr_q[AW]) clr_q <= clr_q + 1'b1;
		end
	end

	// forward the stage-2 byte when the pixel in stage 1 read the same row before that byte was written
	always_comb begin
		wd_s1 = q_s1 | m_s1;
		if (v_s2 && a_s2 == a_s1) wd_s1 = wd_s1 | wd_s2;
	end

	always_ff @(posedge clk) begin
		a_s1     <= idx_full[AW-1:0];
		m_s1     <= 8'h80 >> req.x[2:0];
		a_s2     <= a_s1;
		wd_s2    <= wd_s1;
		q_s1     <= mem[rd_en ? rd_addr : idx_full[AW-1:0]];
		rd_ok_s1 <= 32'(rd_index) < DEPTH;
		if (clear_busy) mem[clr_q[AW-1:0]] <= 8'h00;
		else if (v_s1) mem[a_s1] <= wd_s1;
	end

	assign rd_data = (rd_v_s1 && rd_ok_s1) ? q_s1 : 8'h00;
	assign idle = !v_s1 && !v_s2 && !clear_busy && !hit;
endmodule

FILE: sv/tiled_framebuffer_rasterizer_core.sv
`timescale 1ns / 1ps
// Top level of the tiled framebuffer rasterizer: command sequencer and APB registers.
// Depends on tfr_pkg and tfr_plot.
//
// Draws into a one-bit frame of 8x8 tiles kept in a 256-byte memory (one byte
// per tile row, read-modify-write through a two-stage pipe with forwarding).
// Commands are taken one at a time. A pixel is plotted in its accept cycle;
// otherwise the shape walker issues one pixel per cycle: a line takes its major
// span plus one, a circle eight pixels per octant step (72 for a thick circle),
// a rectangle w*h. A command then drains until the plotter is idle (a clear
// waits until its sweep ends) and holds read_data (zero except for the read
// command) until its transaction is taken, after which the next command can be
// accepted.
// Clear sweeps the memory one byte a cycle; the same sweep runs after reset,
// during which no command is accepted.
module tiled_framebuffer_rasterizer_core import tfr_pkg::*; #(
	parameter int MAX_TILES_WIDE = 8,
	parameter int MAX_TILES_HIGH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [7:0]  radius,
	input  logic [7:0]  rect_width,
	input  logic [7:0]  rect_height,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int DEPTH = MAX_TILES_WIDE * MAX_TILES_HIGH * 8;
	localparam int AW = (DEPTH > 256) ? $clog2(DEPTH) : 8;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LINE  = 6'b000010,
		ST_CIRC  = 6'b000100,
		ST_RECT  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] tw_q;
	logic [2:0] th_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 4'd4;
			th_q <= 3'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == 1'(REG_TILES_WIDE)) tw_q <= pwdata[3:0];
			else th_q <= pwdata[2:0];
		end
	end
	assign prdata = (paddr[2] == 1'(REG_TILES_WIDE)) ? {28'd0, tw_q} : {29'd0, th_q};

	// walker registers
	logic signed [10:0] px_q, py_q, stop_q, err_q, e1_q, e2_q;
	logic               ymaj_q, step_pos_q;
	logic signed [10:0] cx_q, cy_q, ox_q, oy_q, d_q;
	logic [2:0]         oct_q;
	logic [3:0]         blk_q;
	logic               thick_q;
	logic [7:0]         rw_q, rh_q, rx_q, ry_q;
	logic [7:0]         start_x_q, start_y_q;
	logic [2:0]         drain_q;
	logic [7:0]         rd_q;
	logic               rd_pend_q;

	plot_req_t req;
	logic clear_start, clear_busy, idle, rd_en;
	logic [7:0] rd_data;

	tfr_plot #(
		.MAX_TILES_WIDE(MAX_TILES_WIDE), .MAX_TILES_HIGH(MAX_TILES_HIGH),
		.DEPTH(DEPTH), .AW(AW)
	) u_plot (
		.clk, .arst_n, .tiles_wide(tw_q), .tiles_high(th_q), .req,
		.clear_start, .clear_busy, .rd_en, .rd_index(read_index), .rd_data, .idle
	);

	logic acc;
	assign in_ready = (state_q == ST_IDLE) && !clear_busy;
	assign acc = in_valid && in_ready;
	assign clear_start = acc && cmd == CMD_CLEAR;
	assign rd_en = acc && cmd == CMD_READ;

	// circle point for the current octant and 3x3 offset
	logic signed [10:0] cpx, cpy, bx, by;
	always_comb begin
		case (oct_q)
			3'd0: begin cpx = cx_q + ox_q; cpy = cy_q + oy_q; end
			3'd1: begin cpx = cx_q - ox_q; cpy = cy_q + oy_q; end
			3'd2: begin cpx = cx_q + ox_q; cpy = cy_q - oy_q; end
			3'd3: begin cpx = cx_q - ox_q; cpy = cy_q - oy_q; end
			3'd4: begin cpx = cx_q + oy_q; cpy = cy_q + ox_q; end
			3'd5: begin cpx = cx_q - oy_q; cpy = cy_q + ox_q; end
			3'd6: begin cpx = cx_q + oy_q; cpy = cy_q - ox_q; end
			default: begin cpx = cx_q - oy_q; cpy = cy_q - ox_q; end
		endcase
		bx = 11'sd0;
		by = 11'sd0;
		if (thick_q) begin
			case (blk_q) inside
				4'd0, 4'd3, 4'd6: bx = -11'sd1;
				4'd1, 4'd4, 4'd7: bx = 11'sd0;
				default: bx = 11'sd1;
			endcase
			case (blk_q) inside
				[4'd0:4'd2]: by = -11'sd1;
				[4'd3:4'd5]: by = 11'sd0;
				default: by = 11'sd1;
			endcase
		end
	end

	always_comb begin
		req = '0;
		case (state_q)
			ST_LINE: begin req.valid = 1'b1; req.x = px_q[7:0]; req.y = py_q[7:0]; end
			ST_CIRC: begin
				req.valid = 1'b1; req.x = 8'(cpx + bx); req.y = 8'(cpy + by);
			end
			ST_RECT: begin req.valid = 1'b1; req.x = start_x_q + rx_q; req.y = start_y_q + ry_q; end
			default: ;
		endcase
		if (acc && cmd == CMD_PIXEL) begin
			req.valid = 1'b1; req.x = start_x; req.y = start_y;
		end
	end

	logic signed [10:0] dx, dy, adx, ady;
	logic same;
	always_comb begin
		dx = 11'(end_x) - 11'(start_x);
		dy = 11'(end_y) - 11'(start_y);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		same = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			drain_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (acc) begin
					drain_q   <= 3'd4;
					rd_pend_q <= cmd == CMD_READ;
					case (cmd) inside
						CMD_LINE:   state_q <= ST_LINE;
						CMD_CIRCLE, CMD_THICK: state_q <= ST_CIRC;
						CMD_RECT: state_q <= (rect_width == 0 || rect_height == 0)
							? ST_DRAIN : ST_RECT;
						default: state_q <= ST_DRAIN;
					endcase
				end
				ST_LINE: if ((ymaj_q ? py_q : px_q) >= stop_q) state_q <= ST_DRAIN;
				ST_CIRC: if (oct_q == 3'd7 && (!thick_q || blk_q == 4'd8)
					&& !((oy_q - (d_q > 0 ? 11'sd1 : 11'sd0)) >= ox_q + 11'sd1))
					state_q <= ST_DRAIN;
				ST_RECT: if (rx_q == rw_q - 8'd1 && ry_q == rh_q - 8'd1) state_q <= ST_DRAIN;
				ST_DRAIN: begin
					if (drain_q != 0) drain_q <= drain_q - 3'd1;
					else if (idle) state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q && state_q == ST_DRAIN && drain_q == 3'd4) rd_q <= rd_data;
		else if (acc) rd_q <= 8'h00;
		if (acc) begin
			start_x_q <= start_x; start_y_q <= start_y;
			rw_q <= rect_width; rh_q <= rect_height; rx_q <= '0; ry_q <= '0;
			cx_q <= 11'(start_x); cy_q <= 11'(start_y);
			ox_q <= '0; oy_q <= 11'(radius); d_q <= 11'sd3 - 11'(radius) * 11'sd2;
			oct_q <= '0; blk_q <= '0; thick_q <= cmd == CMD_THICK;
			step_pos_q <= same;
			if (ady <= adx) begin
				ymaj_q <= 1'b0; err_q <= 11'(ady * 2) - adx;
				e1_q <= 11'(ady * 2); e2_q <= 11'((ady - adx) * 2);
				if (dx >= 0) begin px_q <= 11'(start_x); py_q <= 11'(start_y); stop_q <= 11'(end_x); end
				else begin px_q <= 11'(end_x); py_q <= 11'(end_y); stop_q <= 11'(start_x); end
			end else begin
				ymaj_q <= 1'b1; err_q <= 11'(adx * 2) - ady;
				e1_q <= 11'(adx * 2); e2_q <= 11'((adx - ady) * 2);
				if (dy >= 0) begin px_q <= 11'(start_x); py_q <= 11'(start_y); stop_q <= 11'(end_y); end
				else begin px_q <= 11'(end_x); py_q <= 11'(end_y); stop_q <= 11'(start_y); end
			end
		end else begin
			if (state_q == ST_LINE) begin
				if (!ymaj_q) begin
					px_q <= px_q + 11'sd1;
					if (err_q < 0) err_q <= err_q + e1_q;
					else begin
						py_q <= step_pos_q ? py_q + 11'sd1 : py_q - 11'sd1;
						err_q <= err_q + e2_q;
					end
				end else begin
					py_q <= py_q + 11'sd1;
					if (err_q <= 0) err_q <= err_q + e1_q;
					else begin
						px_q <= step_pos_q ? px_q + 11'sd1 : px_q - 11'sd1;
						err_q <= err_q + e2_q;
					end
				end
			end
			if (state_q == ST_CIRC) begin
				if (thick_q && blk_q != 4'd8) blk_q <= blk_q + 4'd1;
				else begin
					blk_q <= '0;
					oct_q <= oct_q + 3'd1;
					if (oct_q == 3'd7) begin
						ox_q <= ox_q + 11'sd1;
						if (d_q > 0) begin
							oy_q <= oy_q - 11'sd1;
							d_q <= d_q + ((ox_q + 11'sd1 - oy_q + 11'sd1) <<< 2) + 11'sd10;
						end else d_q <= d_q + ((ox_q + 11'sd1) <<< 2) + 11'sd6;
					end
				end
			end
			if (state_q == ST_RECT) begin
				if (rx_q == rw_q - 8'd1) begin rx_q <= '0; ry_q <= ry_q + 8'd1; end
				else rx_q <= rx_q + 8'd1;
			end
		end
	end

	assign out_valid = state_q == ST_OUT;
	assign read_data = rd_q;
endmodule
